// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the clustering block.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// An antecedent that forces its consequent in the following cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hw/rtl/lmsc_pkg.sv
// Shared constants, codes and helper functions of the clustering block.
// Depends on nothing; used by the top level of the block and by the bench.
`timescale 1ns / 1ps

package lmsc_pkg;

    // Default size limits, handed to the top level as parameter defaults.
    localparam int DEF_MAX_ROWS   = 64;
    localparam int DEF_MAX_COLS   = 64;
    localparam int DEF_MAX_SLICES = 32;
    localparam int DEF_MAX_PASSES = 9;

    // Field widths of the transactions.
    localparam int OP_W    = 2;
    localparam int IDX_W   = 17;
    localparam int RESP_W  = 32;
    localparam int SEED_W  = 16;
    localparam int LABEL_W = 16;
    localparam int PASS_W  = 4;
    localparam int IN_W    = 72;
    localparam int OUT_W   = 24;

    // Configuration register widths and indexes.
    localparam int ROWS_W   = 7;
    localparam int COLS_W   = 7;
    localparam int SLICES_W = 6;
    localparam int RAD_W    = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_SLICES = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_XY  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_Z   = 3'd4;

    localparam logic [ROWS_W-1:0]   RST_NUM_ROWS   = 7'd64;
    localparam logic [COLS_W-1:0]   RST_NUM_COLS   = 7'd64;
    localparam logic [SLICES_W-1:0] RST_NUM_SLICES = 6'd32;
    localparam logic [RAD_W-1:0]    RST_RADIUS_XY  = 4'd2;
    localparam logic [RAD_W-1:0]    RST_RADIUS_Z   = 4'd1;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
    localparam logic [OP_W-1:0] OP_RUN  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ = 2'd2;

    // Seed label that marks background.
    localparam logic [SEED_W-1:0] BACKGROUND_SEED = 16'hFFFF;

    // Lower edge of a window clipped at zero.
    function automatic logic [15:0] lo_bound(input logic [15:0] x, input logic [15:0] r);
        lo_bound = (x > r) ? (x - r) : 16'd0;
    endfunction

    // Upper edge of a window clipped at n - 1.
    function automatic logic [15:0] hi_bound(input logic [15:0] x, input logic [15:0] r,
                                             input logic [15:0] n);
        logic [15:0] s;
        s = x + r;
        hi_bound = (s > (n - 16'd1)) ? (n - 16'd1) : s;
    endfunction

endpackage

// File: hw/rtl/lmsc_ram.sv
// Single-port synchronous memory with registered read data.
// Depends on nothing; instantiated by the clustering top level for each store.
`timescale 1ns / 1ps

module lmsc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 131072,
    parameter int AW    = 17
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read-first access: one address per cycle, data registered for the next cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/lmsc_addr.sv
// Two-stage linear address unit: slice * plane + row * cols + col.
// Depends on nothing; used by the clustering top level for voxel addressing.
`timescale 1ns / 1ps

module lmsc_addr #(
    parameter int RW  = 7,
    parameter int CW  = 7,
    parameter int ZW  = 6,
    parameter int PLW = 13,
    parameter int AW  = 17
) (
    input  logic           i_clk,
    input  logic [ZW-1:0]  i_z,
    input  logic [RW-1:0]  i_r,
    input  logic [CW-1:0]  i_c,
    input  logic [PLW-1:0] i_plane,
    input  logic [CW-1:0]  i_ncols,
    output logic [AW-1:0]  o_addr
);

    logic [AW-1:0] r_zp;
    logic [AW-1:0] r_rc;
    logic [AW-1:0] r_c;
    logic [AW-1:0] r_addr;

    // First stage forms the two products, the second adds them up.
    always_ff @(posedge i_clk) begin
        r_zp   <= AW'(i_z * i_plane);
        r_rc   <= AW'(i_r * i_ncols);
        r_c    <= AW'(i_c);
        r_addr <= r_zp + r_rc + r_c;
    end

    assign o_addr = r_addr;

endmodule

// File: hw/rtl/local_max_seed_clustering_3d.sv
// Top level of the local-maximum seed clustering block: control sequencer and stores.
// Depends on lmsc_pkg, lmsc_ram, lmsc_addr and assert_macros.svh.
//
// Usage. Items arrive on the slave stream: tuser carries the operation, tdata the
// voxel index, response, seed label and foreground bit. Each item gives exactly one
// result transaction on the master stream carrying the label and the pass count.
// A load writes one voxel; a read makes dependent pointer and seed lookups in the
// single-port stores. A run first writes every pointer, then visits each voxel and,
// unless it is a seed, scans its window one response store access at a time; the
// pointer-jumping passes follow, each visiting every voxel.
// One item is worked on at a time; a new item is taken once the sequencer is idle,
// even while the previous result still waits in the output register.
// When the receiver stalls, the finished result is held and the sequencer waits.
// Synchronous reset clears the control state, the pass count and the size and
// radius registers to their defaults; the stores come out of reset undefined and
// must be loaded before a run. Configuration writes are taken at any edge.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module local_max_seed_clustering_3d #(
    parameter int MAX_ROWS   = lmsc_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS   = lmsc_pkg::DEF_MAX_COLS,
    parameter int MAX_SLICES = lmsc_pkg::DEF_MAX_SLICES,
    parameter int MAX_PASSES = lmsc_pkg::DEF_MAX_PASSES
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Slave stream.
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // tdata: voxel_index[16:0], log_value[48:17], seed_label[64:49], foreground[65]
    input  logic [lmsc_pkg::IN_W-1:0]        i_s_axis_tdata,
    // tuser: op[1:0]
    input  logic [lmsc_pkg::OP_W-1:0]        i_s_axis_tuser,
    // Master stream.
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // tdata: label[15:0], passes_done[19:16]
    output logic [lmsc_pkg::OUT_W-1:0]       o_m_axis_tdata,
    // Configuration write port.
    input  logic                             i_cfg_we,
    input  logic [lmsc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lmsc_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);

    localparam int RW    = $clog2(MAX_ROWS + 1);
    localparam int CW    = $clog2(MAX_COLS + 1);
    localparam int ZW    = $clog2(MAX_SLICES + 1);
    localparam int DEPTH = MAX_ROWS * MAX_COLS * MAX_SLICES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PLW   = $clog2(MAX_ROWS * MAX_COLS + 1);
    localparam int TW    = $clog2(DEPTH + 1);
    localparam int PCW   = $clog2(MAX_PASSES + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_PREP1, S_PREP2, S_LOAD, S_RD0, S_RD1, S_RD2, S_INIT,
        S_SW_A0, S_SW_A1, S_SW_SEED, S_SW_CHK, S_WN_A0, S_WN_A1, S_WN_RD, S_WN_CMP,
        S_SW_PB, S_SW_PW, S_SW_NX, S_PS_A0, S_PS_A1, S_PS_RD, S_PS_T, S_PS_W, S_PS_NX,
        S_FIN
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [lmsc_pkg::ROWS_W-1:0]   r_num_rows;
    logic [lmsc_pkg::COLS_W-1:0]   r_num_cols;
    logic [lmsc_pkg::SLICES_W-1:0] r_num_slices;
    logic [lmsc_pkg::RAD_W-1:0]    r_radius_xy;
    logic [lmsc_pkg::RAD_W-1:0]    r_radius_z;

    // Captured item.
    logic [lmsc_pkg::OP_W-1:0]   r_op;
    logic [lmsc_pkg::IDX_W-1:0]  r_idx;
    logic [lmsc_pkg::RESP_W-1:0] r_resp_in;
    logic [lmsc_pkg::SEED_W-1:0] r_seed_in;
    logic                        r_fg_in;

    // Sequencer working registers.
    logic [PLW-1:0] r_plane;
    logic [TW-1:0]  r_total;
    logic [TW-1:0]  r_x;
    logic [RW-1:0]  r_i, r_a, r_r0, r_r1;
    logic [CW-1:0]  r_j, r_b, r_c0, r_c1;
    logic [ZW-1:0]  r_k, r_d, r_z0, r_z1;
    logic [AW-1:0]  r_self, r_best, r_q;
    logic signed [lmsc_pkg::RESP_W-1:0] r_top;
    logic           r_first;
    logic           r_mask;
    logic [PCW-1:0] r_pass;
    logic [PCW-1:0] r_pass_cnt;
    logic           r_changed;
    logic [lmsc_pkg::LABEL_W-1:0] r_label;

    // Output register.
    logic                         r_ovalid;
    logic [lmsc_pkg::LABEL_W-1:0] r_olabel;
    logic [lmsc_pkg::PASS_W-1:0]  r_opass;

    // Clamped sizes.
    logic [RW-1:0] nr;
    logic [CW-1:0] nc;
    logic [ZW-1:0] nz;

    always_comb begin
        if (r_num_rows == '0) begin
            nr = RW'(1);
        end else if (32'(r_num_rows) > 32'(MAX_ROWS)) begin
            nr = RW'(MAX_ROWS);
        end else begin
            nr = RW'(r_num_rows);
        end
        if (r_num_cols == '0) begin
            nc = CW'(1);
        end else if (32'(r_num_cols) > 32'(MAX_COLS)) begin
            nc = CW'(MAX_COLS);
        end else begin
            nc = CW'(r_num_cols);
        end
        if (r_num_slices == '0) begin
            nz = ZW'(1);
        end else if (32'(r_num_slices) > 32'(MAX_SLICES)) begin
            nz = ZW'(MAX_SLICES);
        end else begin
            nz = ZW'(r_num_slices);
        end
    end

    // Index checks on the captured item.
    logic [31:0]   idx_ext;
    logic [AW-1:0] idx_a;
    logic          idx_in_store;
    logic          idx_in_vol;

    assign idx_ext      = 32'(r_idx);
    assign idx_a        = idx_ext[AW-1:0];
    assign idx_in_store = idx_ext < 32'(DEPTH);
    assign idx_in_vol   = idx_ext < 32'(r_total);

    // Scan position tests for the voxel sweep and the window.
    logic k_last, j_last, i_last, d_last, b_last, a_last;

    assign k_last = (r_k == nz - ZW'(1));
    assign j_last = (r_j == nc - CW'(1));
    assign i_last = (r_i == nr - RW'(1));
    assign d_last = (r_d == r_z1);
    assign b_last = (r_b == r_c1);
    assign a_last = (r_a == r_r1);

    // Window bounds of the current voxel.
    logic [RW-1:0] lo_r, hi_r;
    logic [CW-1:0] lo_c, hi_c;
    logic [ZW-1:0] lo_z, hi_z;

    assign lo_r = RW'(lmsc_pkg::lo_bound(16'(r_i), 16'(r_radius_xy)));
    assign hi_r = RW'(lmsc_pkg::hi_bound(16'(r_i), 16'(r_radius_xy), 16'(nr)));
    assign lo_c = CW'(lmsc_pkg::lo_bound(16'(r_j), 16'(r_radius_xy)));
    assign hi_c = CW'(lmsc_pkg::hi_bound(16'(r_j), 16'(r_radius_xy), 16'(nc)));
    assign lo_z = ZW'(lmsc_pkg::lo_bound(16'(r_k), 16'(r_radius_z)));
    assign hi_z = ZW'(lmsc_pkg::hi_bound(16'(r_k), 16'(r_radius_z), 16'(nz)));

    // Address unit shared by the voxel sweep, the window scan and the pointer passes.
    logic          sel_win;
    logic [ZW-1:0] au_z;
    logic [RW-1:0] au_r;
    logic [CW-1:0] au_c;
    logic [AW-1:0] au_addr;

    assign sel_win = (r_state == S_WN_A0) || (r_state == S_WN_A1);
    assign au_z    = sel_win ? r_d : r_k;
    assign au_r    = sel_win ? r_a : r_i;
    assign au_c    = sel_win ? r_b : r_j;

    lmsc_addr #(
        .RW (RW),
        .CW (CW),
        .ZW (ZW),
        .PLW(PLW),
        .AW (AW)
    ) u_addr (
        .i_clk  (i_clk),
        .i_z    (au_z),
        .i_r    (au_r),
        .i_c    (au_c),
        .i_plane(r_plane),
        .i_ncols(nc),
        .o_addr (au_addr)
    );

    // Stores.
    logic                          resp_we, seed_we, mask_we, ptr_we;
    logic [AW-1:0]                 resp_addr, seed_addr, mask_addr, ptr_addr;
    logic [AW-1:0]                 ptr_wdata;
    logic [lmsc_pkg::RESP_W-1:0]   resp_rdata;
    logic [lmsc_pkg::SEED_W-1:0]   seed_rdata;
    logic                          mask_rdata;
    logic [AW-1:0]                 ptr_rdata;

    lmsc_ram #(.WIDTH(lmsc_pkg::RESP_W), .DEPTH(DEPTH), .AW(AW)) u_resp (
        .i_clk(i_clk), .i_we(resp_we), .i_addr(resp_addr), .i_wdata(r_resp_in),
        .o_rdata(resp_rdata)
    );

    lmsc_ram #(.WIDTH(lmsc_pkg::SEED_W), .DEPTH(DEPTH), .AW(AW)) u_seed (
        .i_clk(i_clk), .i_we(seed_we), .i_addr(seed_addr), .i_wdata(r_seed_in),
        .o_rdata(seed_rdata)
    );

    lmsc_ram #(.WIDTH(1), .DEPTH(DEPTH), .AW(AW)) u_mask (
        .i_clk(i_clk), .i_we(mask_we), .i_addr(mask_addr), .i_wdata(r_fg_in),
        .o_rdata(mask_rdata)
    );

    lmsc_ram #(.WIDTH(AW), .DEPTH(DEPTH), .AW(AW)) u_ptr (
        .i_clk(i_clk), .i_we(ptr_we), .i_addr(ptr_addr), .i_wdata(ptr_wdata),
        .o_rdata(ptr_rdata)
    );

    // Store access steering by sequencer state.
    always_comb begin
        resp_we   = 1'b0;
        seed_we   = 1'b0;
        mask_we   = 1'b0;
        ptr_we    = 1'b0;
        resp_addr = '0;
        seed_addr = '0;
        mask_addr = '0;
        ptr_addr  = '0;
        ptr_wdata = ptr_rdata;
        case (r_state)
            S_LOAD: begin
                resp_we   = idx_in_store;
                seed_we   = idx_in_store;
                mask_we   = idx_in_store;
                resp_addr = idx_a;
                seed_addr = idx_a;
                mask_addr = idx_a;
            end
            S_RD0: begin
                ptr_addr  = idx_a;
                mask_addr = idx_a;
            end
            S_RD1: begin
                seed_addr = ptr_rdata;
            end
            S_INIT: begin
                ptr_we    = 1'b1;
                ptr_addr  = r_x[AW-1:0];
                ptr_wdata = r_x[AW-1:0];
            end
            S_SW_SEED: begin
                seed_addr = au_addr;
            end
            S_WN_RD: begin
                resp_addr = au_addr;
            end
            S_SW_PB: begin
                ptr_addr = r_best;
            end
            S_SW_PW: begin
                ptr_we   = 1'b1;
                ptr_addr = r_self;
            end
            S_PS_RD: begin
                ptr_addr  = au_addr;
                seed_addr = au_addr;
            end
            S_PS_T: begin
                ptr_addr  = ptr_rdata;
                seed_addr = ptr_rdata;
            end
            S_PS_W: begin
                ptr_we   = (seed_rdata == '0);
                ptr_addr = r_self;
            end
            default: begin
            end
        endcase
    end

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows   <= lmsc_pkg::RST_NUM_ROWS;
            r_num_cols   <= lmsc_pkg::RST_NUM_COLS;
            r_num_slices <= lmsc_pkg::RST_NUM_SLICES;
            r_radius_xy  <= lmsc_pkg::RST_RADIUS_XY;
            r_radius_z   <= lmsc_pkg::RST_RADIUS_Z;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                lmsc_pkg::CFG_NUM_ROWS:   r_num_rows   <= i_cfg_wdata[lmsc_pkg::ROWS_W-1:0];
                lmsc_pkg::CFG_NUM_COLS:   r_num_cols   <= i_cfg_wdata[lmsc_pkg::COLS_W-1:0];
                lmsc_pkg::CFG_NUM_SLICES: r_num_slices <= i_cfg_wdata[lmsc_pkg::SLICES_W-1:0];
                lmsc_pkg::CFG_RADIUS_XY:  r_radius_xy  <= i_cfg_wdata[lmsc_pkg::RAD_W-1:0];
                lmsc_pkg::CFG_RADIUS_Z:   r_radius_z   <= i_cfg_wdata[lmsc_pkg::RAD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {4'd0, r_opass, r_olabel};

    // Sequencer: holds state, working registers and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ovalid   <= 1'b0;
            r_pass_cnt <= '0;
            r_pass     <= '0;
            r_changed  <= 1'b0;
            r_first    <= 1'b0;
        end else begin
            // The final state reloads the output register itself.
            if (r_ovalid && i_m_axis_tready && (r_state != S_FIN)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_op      <= i_s_axis_tuser;
                        r_idx     <= i_s_axis_tdata[16:0];
                        r_resp_in <= i_s_axis_tdata[48:17];
                        r_seed_in <= i_s_axis_tdata[64:49];
                        r_fg_in   <= i_s_axis_tdata[65];
                        r_label   <= '0;
                        r_state   <= S_PREP1;
                    end
                end
                S_PREP1: begin
                    r_plane <= PLW'(nr * nc);
                    r_state <= S_PREP2;
                end
                S_PREP2: begin
                    r_total <= TW'(r_plane * nz);
                    r_x     <= '0;
                    case (r_op)
                        lmsc_pkg::OP_LOAD: r_state <= S_LOAD;
                        lmsc_pkg::OP_RUN:  r_state <= S_INIT;
                        lmsc_pkg::OP_READ: r_state <= S_RD0;
                        default:           r_state <= S_FIN;
                    endcase
                end
                S_LOAD: begin
                    r_state <= S_FIN;
                end
                // Read: pointer and mask, then the target's seed label.
                S_RD0: begin
                    r_state <= idx_in_vol ? S_RD1 : S_FIN;
                end
                S_RD1: begin
                    r_mask  <= mask_rdata;
                    r_state <= S_RD2;
                end
                S_RD2: begin
                    if ((seed_rdata != lmsc_pkg::BACKGROUND_SEED) && r_mask) begin
                        r_label <= seed_rdata;
                    end
                    r_state <= S_FIN;
                end
                // Every pointer starts at its own voxel.
                S_INIT: begin
                    if (r_x == r_total - TW'(1)) begin
                        r_i     <= '0;
                        r_j     <= '0;
                        r_k     <= '0;
                        r_state <= S_SW_A0;
                    end else begin
                        r_x <= r_x + TW'(1);
                    end
                end
                S_SW_A0: r_state <= S_SW_A1;
                S_SW_A1: r_state <= S_SW_SEED;
                S_SW_SEED: begin
                    r_self  <= au_addr;
                    r_r0    <= lo_r;
                    r_r1    <= hi_r;
                    r_c0    <= lo_c;
                    r_c1    <= hi_c;
                    r_z0    <= lo_z;
                    r_z1    <= hi_z;
                    r_a     <= lo_r;
                    r_b     <= lo_c;
                    r_d     <= lo_z;
                    r_first <= 1'b1;
                    r_state <= S_SW_CHK;
                end
                S_SW_CHK: begin
                    r_state <= (seed_rdata != '0) ? S_SW_NX : S_WN_A0;
                end
                // Window scan: last maximum in scan order wins.
                S_WN_A0: r_state <= S_WN_A1;
                S_WN_A1: r_state <= S_WN_RD;
                S_WN_RD: begin
                    r_q     <= au_addr;
                    r_state <= S_WN_CMP;
                end
                S_WN_CMP: begin
                    if (r_first || ($signed(resp_rdata) >= r_top)) begin
                        r_top  <= $signed(resp_rdata);
                        r_best <= r_q;
                    end
                    r_first <= 1'b0;
                    if (!d_last) begin
                        r_d     <= r_d + ZW'(1);
                        r_state <= S_WN_A0;
                    end else if (!b_last) begin
                        r_d     <= r_z0;
                        r_b     <= r_b + CW'(1);
                        r_state <= S_WN_A0;
                    end else if (!a_last) begin
                        r_d     <= r_z0;
                        r_b     <= r_c0;
                        r_a     <= r_a + RW'(1);
                        r_state <= S_WN_A0;
                    end else begin
                        r_state <= S_SW_PB;
                    end
                end
                S_SW_PB: r_state <= S_SW_PW;
                S_SW_PW: r_state <= S_SW_NX;
                S_SW_NX: begin
                    if (!k_last) begin
                        r_k     <= r_k + ZW'(1);
                        r_state <= S_SW_A0;
                    end else if (!j_last) begin
                        r_k     <= '0;
                        r_j     <= r_j + CW'(1);
                        r_state <= S_SW_A0;
                    end else if (!i_last) begin
                        r_k     <= '0;
                        r_j     <= '0;
                        r_i     <= r_i + RW'(1);
                        r_state <= S_SW_A0;
                    end else begin
                        r_i       <= '0;
                        r_j       <= '0;
                        r_k       <= '0;
                        r_pass    <= PCW'(1);
                        r_changed <= 1'b0;
                        r_state   <= S_PS_A0;
                    end
                end
                // Pointer-jumping pass.
                S_PS_A0: r_state <= S_PS_A1;
                S_PS_A1: r_state <= S_PS_RD;
                S_PS_RD: begin
                    r_self  <= au_addr;
                    r_state <= S_PS_T;
                end
                S_PS_T: begin
                    if ((ptr_rdata == '0) || (seed_rdata != '0)) begin
                        r_state <= S_PS_NX;
                    end else begin
                        r_state <= S_PS_W;
                    end
                end
                S_PS_W: begin
                    if (seed_rdata == '0) begin
                        r_changed <= 1'b1;
                    end
                    r_state <= S_PS_NX;
                end
                S_PS_NX: begin
                    if (!k_last) begin
                        r_k     <= r_k + ZW'(1);
                        r_state <= S_PS_A0;
                    end else if (!j_last) begin
                        r_k     <= '0;
                        r_j     <= r_j + CW'(1);
                        r_state <= S_PS_A0;
                    end else if (!i_last) begin
                        r_k     <= '0;
                        r_j     <= '0;
                        r_i     <= r_i + RW'(1);
                        r_state <= S_PS_A0;
                    end else begin
                        r_pass_cnt <= r_pass;
                        if (!r_changed || (r_pass == PCW'(MAX_PASSES))) begin
                            r_state <= S_FIN;
                        end else begin
                            r_i       <= '0;
                            r_j       <= '0;
                            r_k       <= '0;
                            r_pass    <= r_pass + PCW'(1);
                            r_changed <= 1'b0;
                            r_state   <= S_PS_A0;
                        end
                    end
                end
                // Hand the result over once the output register is free.
                S_FIN: begin
                    if (!r_ovalid || i_m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        r_olabel <= r_label;
                        r_opass  <= lmsc_pkg::PASS_W'(r_pass_cnt);
                        r_state  <= S_IDLE;
                    end else begin
                        r_ovalid <= 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Conditions watched by the checks below.
    logic in_accept;
    logic any_we;
    logic fin_stall;

    assign in_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign any_we    = resp_we || seed_we || mask_we || ptr_we;
    assign fin_stall = (r_state == S_FIN) && r_ovalid && !i_m_axis_tready;

    // Checks on the sequencer.
    `ASSERT_ALWAYS(a_pass_bound, i_clk, i_rst_n, (32'(r_pass_cnt) <= 32'(MAX_PASSES)))
    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, in_accept, (r_state != S_IDLE))
    `ASSERT_ALWAYS(a_no_idle_write, i_clk, i_rst_n, (!any_we || (r_state != S_IDLE)))
    `ASSERT_NEXT(a_fin_hold, i_clk, i_rst_n, fin_stall, (r_state == S_FIN))

endmodule

// File: bench/testbench.sv
// Self-checking bench for the local-maximum seed clustering block.
// Depends on lmsc_pkg and local_max_seed_clustering_3d; holds its own predictor.
`timescale 1ns / 1ps

module testbench;

    localparam int DEPTH      = 131072;
    localparam int NPASS      = 9;
    localparam int CYCLE_CAP  = 10000000;

    // Operation code that the block ignores.
    localparam logic [lmsc_pkg::OP_W-1:0] OP_NONE = 2'd3;

    typedef struct packed {
        logic [lmsc_pkg::OP_W-1:0]     op;
        logic [lmsc_pkg::IDX_W-1:0]    idx;
        logic [lmsc_pkg::RESP_W-1:0]   resp;
        logic [lmsc_pkg::SEED_W-1:0]   seed;
        logic                          fg;
    } t_voxel_cmd;

    typedef struct packed {
        logic [lmsc_pkg::LABEL_W-1:0]  label;
        logic [lmsc_pkg::PASS_W-1:0]   passes;
    } t_label_out;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_s_axis_tvalid = 1'b0;
    logic                              o_s_axis_tready;
    logic [lmsc_pkg::IN_W-1:0]         i_s_axis_tdata = '0;
    logic [lmsc_pkg::OP_W-1:0]         i_s_axis_tuser = '0;
    logic                              o_m_axis_tvalid;
    logic                              i_m_axis_tready = 1'b0;
    logic [lmsc_pkg::OUT_W-1:0]        o_m_axis_tdata;
    logic                              i_cfg_we = 1'b0;
    logic [lmsc_pkg::CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [lmsc_pkg::CFG_DATA_W-1:0]   i_cfg_wdata = '0;

    local_max_seed_clustering_3d uut (.*);

    always #4 i_clk = ~i_clk;

    // Predictor state: a copy of the stores, the pass count and the registers.
    logic signed [31:0]  resp_mem [DEPTH];
    logic [15:0]         seed_mem [DEPTH];
    logic                mask_mem [DEPTH];
    logic [16:0]         ptr_mem  [DEPTH];
    logic [3:0]          pass_cnt = '0;
    logic [6:0]          reg_rows = 7'd64, reg_cols = 7'd64;
    logic [5:0]          reg_slices = 6'd32;
    logic [3:0]          reg_rxy = 4'd2, reg_rz = 4'd1;

    t_voxel_cmd  cmd_queue [$];
    t_label_out  label_due [$];
    t_voxel_cmd  cmd_cur;
    int          sender_idle = 20, receiver_idle = 65;
    int          mismatches = 0;
    int          accepted = 0;
    int          cycles = 0;

    function automatic int clamp_dim(input int v, input int hi);
        if (v == 0) return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic int volume_size();
        return clamp_dim(reg_rows, 64) * clamp_dim(reg_cols, 64) * clamp_dim(reg_slices, 32);
    endfunction

    // Seed clustering of the whole volume in use, as the block does on a run.
    function automatic void cluster_volume();
        int nr, nc, nz, plane, total, self, best, q, t;
        int r0, r1, c0, c1, z0, z1;
        logic signed [31:0] top;
        bit changed;
        nr = clamp_dim(reg_rows, 64);
        nc = clamp_dim(reg_cols, 64);
        nz = clamp_dim(reg_slices, 32);
        plane = nr * nc;
        total = plane * nz;
        for (int x = 0; x < total; x++) ptr_mem[x] = 17'(x);
        for (int i = 0; i < nr; i++)
            for (int j = 0; j < nc; j++)
                for (int k = 0; k < nz; k++) begin
                    self = k * plane + i * nc + j;
                    if (seed_mem[self] != 0) continue;
                    r0 = (i > reg_rxy) ? i - reg_rxy : 0;
                    r1 = (i + reg_rxy > nr - 1) ? nr - 1 : i + reg_rxy;
                    c0 = (j > reg_rxy) ? j - reg_rxy : 0;
                    c1 = (j + reg_rxy > nc - 1) ? nc - 1 : j + reg_rxy;
                    z0 = (k > reg_rz) ? k - reg_rz : 0;
                    z1 = (k + reg_rz > nz - 1) ? nz - 1 : k + reg_rz;
                    best = z0 * plane + r0 * nc + c0;
                    top = resp_mem[best];
                    for (int a = r0; a <= r1; a++)
                        for (int b = c0; b <= c1; b++)
                            for (int d = z0; d <= z1; d++) begin
                                q = d * plane + a * nc + b;
                                if (resp_mem[q] >= top) begin
                                    top = resp_mem[q];
                                    best = q;
                                end
                            end
                    ptr_mem[self] = ptr_mem[best];
                end
        pass_cnt = '0;
        for (int p = 1; p <= NPASS; p++) begin
            changed = 0;
            for (int i = 0; i < nr; i++)
                for (int j = 0; j < nc; j++)
                    for (int k = 0; k < nz; k++) begin
                        self = k * plane + i * nc + j;
                        t = int'(ptr_mem[self]);
                        if (t == 0) continue;
                        if (seed_mem[self] != 0 || seed_mem[t] != 0) continue;
                        changed = 1;
                        ptr_mem[self] = ptr_mem[t];
                    end
            pass_cnt = 4'(p);
            if (!changed) break;
        end
    endfunction

    // Expected result of one accepted command; updates the predictor state.
    function automatic t_label_out predict_label(input t_voxel_cmd c);
        t_label_out r;
        logic [16:0] t;
        r.label = '0;
        case (c.op)
            lmsc_pkg::OP_LOAD: begin
                resp_mem[c.idx] = c.resp;
                seed_mem[c.idx] = c.seed;
                mask_mem[c.idx] = c.fg;
            end
            lmsc_pkg::OP_RUN: cluster_volume();
            lmsc_pkg::OP_READ: begin
                if (int'(c.idx) < volume_size()) begin
                    t = ptr_mem[c.idx];
                    if (seed_mem[t] != lmsc_pkg::BACKGROUND_SEED && mask_mem[c.idx])
                        r.label = seed_mem[t];
                end
            end
            default: ;
        endcase
        r.passes = pass_cnt;
        return r;
    endfunction

    // Driver: takes pending commands and presents them on the slave stream.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                label_due.push_back(predict_label(cmd_cur));
                accepted++;
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (cmd_queue.size() > 0 && $urandom_range(99) >= sender_idle) begin
                    cmd_cur = cmd_queue.pop_front();
                    i_s_axis_tdata <= {6'd0, cmd_cur.fg, cmd_cur.seed, cmd_cur.resp, cmd_cur.idx};
                    i_s_axis_tuser <= cmd_cur.op;
                    i_s_axis_tvalid <= 1'b1;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random back-pressure and comparison with the oldest expectation.
    always @(posedge i_clk) begin
        t_label_out want;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (label_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transaction %h", o_m_axis_tdata);
                end else begin
                    want = label_due.pop_front();
                    if (o_m_axis_tdata[15:0] !== want.label
                        || o_m_axis_tdata[19:16] !== want.passes) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: label exp %0d got %0d, passes exp %0d got %0d",
                                     want.label, o_m_axis_tdata[15:0],
                                     want.passes, o_m_axis_tdata[19:16]);
                    end
                end
            end
            i_m_axis_tready <= ($urandom_range(99) >= receiver_idle);
        end
    end

    // Idling pattern follows the number of accepted transactions.
    always @(posedge i_clk) begin
        if (accepted < 400) begin
            sender_idle <= 20;
            receiver_idle <= 65;
        end else if (accepted < 800) begin
            sender_idle <= 65;
            receiver_idle <= 20;
        end else begin
            sender_idle <= 0;
            receiver_idle <= 0;
        end
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("testbench failed");
            $finish;
        end
    end

    task automatic add_cmd(input logic [1:0] op, input int idx, input logic [31:0] resp,
                           input logic [15:0] seed, input logic fg);
        t_voxel_cmd c;
        c.op = op;
        c.idx = lmsc_pkg::IDX_W'(idx);
        c.resp = resp;
        c.seed = seed;
        c.fg = fg;
        cmd_queue.push_back(c);
    endtask

    function automatic logic [31:0] rand_resp();
        if ($urandom_range(3) == 0) return $urandom;
        return 32'($urandom_range(7)) - 32'd3;
    endfunction

    function automatic logic [15:0] rand_seed();
        int s;
        s = $urandom_range(99);
        if (s < 65) return 16'd0;
        if (s < 75) return lmsc_pkg::BACKGROUND_SEED;
        if (s < 90) return 16'($urandom_range(9) + 1);
        return 16'($urandom);
    endfunction

    // Waits until every command is accepted and every result has arrived.
    task automatic drain();
        while (cmd_queue.size() > 0 || i_s_axis_tvalid || label_due.size() > 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [6:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            lmsc_pkg::CFG_NUM_ROWS:   reg_rows = val;
            lmsc_pkg::CFG_NUM_COLS:   reg_cols = val;
            lmsc_pkg::CFG_NUM_SLICES: reg_slices = val[5:0];
            lmsc_pkg::CFG_RADIUS_XY:  reg_rxy = val[3:0];
            default:                  reg_rz = val[3:0];
        endcase
    endtask

    task automatic set_volume(input int r, input int c, input int z, input int rxy, input int rz);
        write_reg(lmsc_pkg::CFG_NUM_ROWS, 7'(r));
        write_reg(lmsc_pkg::CFG_NUM_COLS, 7'(c));
        write_reg(lmsc_pkg::CFG_NUM_SLICES, 7'(z));
        write_reg(lmsc_pkg::CFG_RADIUS_XY, 7'(rxy));
        write_reg(lmsc_pkg::CFG_RADIUS_Z, 7'(rz));
    endtask

    task automatic load_volume();
        for (int x = 0; x < volume_size(); x++)
            add_cmd(lmsc_pkg::OP_LOAD, x, rand_resp(), rand_seed(), 1'($urandom_range(1)));
    endtask

    // Stimulus: a directed phase, then random phases, each ending idle.
    initial begin
        int issued, pick, total;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: 3x3x2 volume with extreme responses, ties and every kind of seed.
        set_volume(3, 3, 2, 1, 1);
        for (int x = 0; x < 18; x++)
            add_cmd(lmsc_pkg::OP_LOAD, x,
                    (x == 4) ? 32'h7FFF_FFFF : (x == 13) ? 32'h8000_0000 : 32'd5,
                    (x == 0) ? 16'd7 : (x == 17) ? lmsc_pkg::BACKGROUND_SEED :
                    (x == 9) ? 16'hFFFE : 16'd0,
                    (x % 5) != 3);
        add_cmd(lmsc_pkg::OP_LOAD, 131071, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
        add_cmd(lmsc_pkg::OP_RUN, 0, '0, '0, 1'b0);
        add_cmd(lmsc_pkg::OP_READ, 0, '0, '0, 1'b0);
        add_cmd(lmsc_pkg::OP_READ, 17, '0, '0, 1'b0);
        add_cmd(lmsc_pkg::OP_READ, 18, '0, '0, 1'b0);
        add_cmd(lmsc_pkg::OP_READ, 131071, '0, '0, 1'b0);
        add_cmd(OP_NONE, 5, '1, '1, 1'b1);
        drain();

        issued = 26;
        for (int ph = 0; issued < 1200; ph++) begin
            // Extreme sizes and radii now and then, small volumes otherwise.
            case (ph % 6)
                1: set_volume(64, 1, 1, 15, 15);
                2: set_volume(1, 64, 1, 0, 0);
                3: set_volume(1, 1, 32, 15, 15);
                4: set_volume(0, 127, 0, $urandom_range(15), 0);
                5: set_volume(1, 1, 63, 0, $urandom_range(15));
                default: set_volume($urandom_range(5) + 1, $urandom_range(5) + 1,
                                    $urandom_range(3) + 1, $urandom_range(3),
                                    $urandom_range(3));
            endcase
            total = volume_size();
            load_volume();
            add_cmd(lmsc_pkg::OP_RUN, $urandom, '0, '0, 1'b0);
            for (int n = 0; n < 40; n++) begin
                pick = $urandom_range(99);
                if (pick < 25)
                    add_cmd(lmsc_pkg::OP_LOAD, $urandom_range(total - 1), rand_resp(),
                            rand_seed(), 1'($urandom_range(1)));
                else if (pick < 35)
                    add_cmd(lmsc_pkg::OP_LOAD, total + $urandom_range(DEPTH - 1 - total),
                            $urandom, 16'($urandom), 1'($urandom_range(1)));
                else if (pick < 82)
                    add_cmd(lmsc_pkg::OP_READ, $urandom_range(total - 1), $urandom,
                            16'($urandom), 1'b0);
                else if (pick < 88)
                    add_cmd(lmsc_pkg::OP_READ, $urandom_range(DEPTH - 1), $urandom,
                            16'($urandom), 1'b1);
                else if (pick < 95)
                    add_cmd(lmsc_pkg::OP_RUN, $urandom, $urandom, 16'($urandom),
                            1'($urandom_range(1)));
                else
                    add_cmd(OP_NONE, $urandom, $urandom, 16'($urandom),
                            1'($urandom_range(1)));
            end
            issued += total + 41;
            drain();
        end

        if (mismatches == 0 && label_due.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
